>>> hw/rtl/rgsm_pkg.sv
// Shared types and constants for the gray-conversion Sobel edge block.
// No dependencies; compile first.
package rgsm_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = 12;
    localparam int PIX_W      = 8;
    localparam int FW_W       = 11;
    localparam int FH_W       = 12;
    localparam int GRAY_SUM_W = 24;
    localparam int SOBEL_W    = PIX_W + 2;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 12;

    typedef logic [PIX_W-1:0]       pixel_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

    // register indexes
    localparam cfg_index_t REG_FRAME_WIDTH  = cfg_index_t'(0);
    localparam cfg_index_t REG_FRAME_HEIGHT = cfg_index_t'(1);

    localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
    localparam logic [FW_W-1:0] FW_MIN   = FW_W'(3);
    localparam logic [FW_W-1:0] FW_MAX   = FW_W'(MAX_WIDTH);
    localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);
    localparam logic [FH_W-1:0] FH_MIN   = FH_W'(3);

    // luma weights, Q0.16; they sum to 65536 so the gray value never overflows
    localparam logic [15:0] W_RED   = 16'd13933;
    localparam logic [15:0] W_GREEN = 16'd46871;
    localparam logic [15:0] W_BLUE  = 16'd4732;

    localparam pixel_t MAG_MAX = pixel_t'(255);

endpackage

>>> hw/rtl/rgsm_ifs.sv
// Handshake channel interfaces: pixel input, result output, register writes.
// Depends on rgsm_pkg.
interface rgsm_pixel_if import rgsm_pkg::*; ();
    logic   valid;
    logic   ready;
    pixel_t blue;
    pixel_t green;
    pixel_t red;

    modport source (output valid, blue, green, red, input ready);
    modport sink   (input valid, blue, green, red, output ready);
endinterface

interface rgsm_result_if import rgsm_pkg::*; ();
    logic   valid;
    logic   ready;
    pixel_t magnitude;
    logic   row_end;
    logic   frame_end;

    modport source (output valid, magnitude, row_end, frame_end, input ready);
    modport sink   (input valid, magnitude, row_end, frame_end, output ready);
endinterface

interface rgsm_cfg_if import rgsm_pkg::*; ();
    logic       valid;
    logic       ready;
    cfg_index_t index;
    cfg_data_t  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/rgb_gray_sobel_magnitude_top.sv
// Colour-to-gray 3x3 Sobel edge detector, |Gx|+|Gy| saturated to 255.
// Depends on rgsm_pkg and the interfaces in rgsm_ifs.sv.
//
// pixel  : raster-order BGR items, one pixel each, valid/ready.
// result : one item per interior pixel (frame shrinks by two rows and two
//          columns), with row_end / frame_end marks, valid/ready.
// cfg    : register writes (index 0 frame_width, 1 frame_height), always
//          ready; write only when the block is drained.
// Throughput is one item per cycle while the receiver keeps up. Pipeline
// is input stage (line store read), gray stage (three 16x8 multiplies),
// Sobel stage into the output register.
// A stalled receiver only holds the output register; earlier stages keep
// filling until they are full, then pixel.ready drops.
// Reset: counters and window cleared, frame 640x480. Line stores are not
// cleared; rows are always written before they are read.
module rgb_gray_sobel_magnitude_top import rgsm_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    rgsm_pixel_if.sink     pixel,
    rgsm_result_if.source  result,
    rgsm_cfg_if.sink       cfg
);

    // configuration
    logic [FW_W-1:0] fw_reg;
    logic [FH_W-1:0] fh_reg;
    logic [FW_W-1:0] eff_w;
    logic [FH_W-1:0] eff_h;

    // raster position of the next pixel
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_eff;
    logic             last_col, last_row, produce;

    // handshake / flow
    logic accept, s1_move, s1_free, s2_move, s2_free, out_free;

    // input stage
    logic             s1_valid_reg;
    pixel_t           s1_blue_reg, s1_green_reg, s1_red_reg;
    logic [COL_W-1:0] s1_idx_reg;
    logic             s1_produce_reg, s1_row_end_reg, s1_frame_end_reg;
    pixel_t           top_rd_reg, mid_rd_reg;

    // gray stage
    logic [GRAY_SUM_W-1:0] gray_sum;
    pixel_t                gray;
    logic                  s2_valid_reg;
    pixel_t                s2_gray_reg, s2_top_reg, s2_mid_reg;
    logic [COL_W-1:0]      s2_idx_reg;
    logic                  s2_produce_reg, s2_row_end_reg, s2_frame_end_reg;

    // window: [0..2] two columns back (top, mid, bottom), [3..5] one back
    pixel_t win_reg [6];

    // Sobel
    logic [SOBEL_W-1:0] right_sum, left_sum, lower_sum, upper_sum;
    logic [SOBEL_W-1:0] dx_abs, dy_abs;
    logic [SOBEL_W:0]   mag_sum;
    pixel_t             mag;

    // output register
    logic   out_valid_reg;
    pixel_t mag_reg;
    logic   row_end_reg, frame_end_reg;

    // line stores
    pixel_t line_one_mem [MAX_WIDTH];
    pixel_t line_two_mem [MAX_WIDTH];

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= FW_RESET;
            fh_reg <= FH_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_FRAME_WIDTH:  fw_reg <= cfg.data[FW_W-1:0];
                REG_FRAME_HEIGHT: fh_reg <= cfg.data[FH_W-1:0];
                default:          ;
            endcase
        end
    end

    // Out-of-range sizes are clamped
    always_comb
    begin
        if (fw_reg < FW_MIN)
            eff_w = FW_MIN;
        else if (fw_reg > FW_MAX)
            eff_w = FW_MAX;
        else
            eff_w = fw_reg;
        eff_h = (fh_reg < FH_MIN) ? FH_MIN : fh_reg;
    end

    // ---------------------------------------------------------------
    // Flow control: each stage moves when the one after it has room.
    // Items with no result leave the gray stage without needing the
    // output register.
    // ---------------------------------------------------------------
    assign out_free    = !out_valid_reg || result.ready;
    assign s2_move     = s2_valid_reg && (!s2_produce_reg || out_free);
    assign s2_free     = !s2_valid_reg || s2_move;
    assign s1_move     = s1_valid_reg && s2_free;
    assign s1_free     = !s1_valid_reg || s1_move;
    assign pixel.ready = s1_free;
    assign accept      = pixel.valid && s1_free;

    // ---------------------------------------------------------------
    // Raster position. A column past the end (after narrowing the frame)
    // is taken as the last column.
    // ---------------------------------------------------------------
    always_comb
    begin
        if (FW_W'(col_reg) >= eff_w)
            col_eff = COL_W'(eff_w - FW_W'(1));
        else
            col_eff = col_reg;
        last_col = FW_W'(col_eff) >= (eff_w - FW_W'(1));
        last_row = FH_W'(row_reg) >= (eff_h - FH_W'(1));
        produce  = (row_reg >= ROW_W'(2)) && (col_eff >= COL_W'(2));
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_eff + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------------------------------------------------------
    // Line stores. Read at acceptance, written when the item leaves the
    // gray stage. The same entry is next read a full row later (at least
    // three items), so read and write never collide.
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            line_one_mem[s2_idx_reg] <= s2_gray_reg;
            line_two_mem[s2_idx_reg] <= s2_mid_reg;
        end
        if (accept)
        begin
            top_rd_reg <= line_two_mem[col_eff];
            mid_rd_reg <= line_one_mem[col_eff];
        end
    end

    // ---------------------------------------------------------------
    // Input stage
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_free)
            s1_valid_reg <= pixel.valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_blue_reg      <= pixel.blue;
            s1_green_reg     <= pixel.green;
            s1_red_reg       <= pixel.red;
            s1_idx_reg       <= col_eff;
            s1_produce_reg   <= produce;
            s1_row_end_reg   <= last_col;
            s1_frame_end_reg <= last_col && last_row;
        end
    end

    // ---------------------------------------------------------------
    // Gray stage: weighted sum, top byte kept (truncation)
    // ---------------------------------------------------------------
    assign gray_sum = GRAY_SUM_W'(W_RED)   * GRAY_SUM_W'(s1_red_reg)
                    + GRAY_SUM_W'(W_GREEN) * GRAY_SUM_W'(s1_green_reg)
                    + GRAY_SUM_W'(W_BLUE)  * GRAY_SUM_W'(s1_blue_reg);
    assign gray     = gray_sum[GRAY_SUM_W-1 -: PIX_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_free)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_gray_reg      <= gray;
            s2_top_reg       <= top_rd_reg;
            s2_mid_reg       <= mid_rd_reg;
            s2_idx_reg       <= s1_idx_reg;
            s2_produce_reg   <= s1_produce_reg;
            s2_row_end_reg   <= s1_row_end_reg;
            s2_frame_end_reg <= s1_frame_end_reg;
        end
    end

    // ---------------------------------------------------------------
    // Sobel stage. Incoming column is (top, mid, gray).
    // ---------------------------------------------------------------
    always_comb
    begin
        right_sum = SOBEL_W'(s2_top_reg) + {1'b0, s2_mid_reg, 1'b0} + SOBEL_W'(s2_gray_reg);
        left_sum  = SOBEL_W'(win_reg[0]) + {1'b0, win_reg[1], 1'b0} + SOBEL_W'(win_reg[2]);
        lower_sum = SOBEL_W'(win_reg[2]) + {1'b0, win_reg[5], 1'b0} + SOBEL_W'(s2_gray_reg);
        upper_sum = SOBEL_W'(win_reg[0]) + {1'b0, win_reg[3], 1'b0} + SOBEL_W'(s2_top_reg);
        dx_abs    = (right_sum > left_sum)  ? right_sum - left_sum  : left_sum - right_sum;
        dy_abs    = (lower_sum > upper_sum) ? lower_sum - upper_sum : upper_sum - lower_sum;
        mag_sum   = {1'b0, dx_abs} + {1'b0, dy_abs};
        mag       = (mag_sum > (SOBEL_W+1)'(MAG_MAX)) ? MAG_MAX : mag_sum[PIX_W-1:0];
    end

    // window shifts once per item, result or not
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else if (s2_move)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= s2_top_reg;
            win_reg[4] <= s2_mid_reg;
            win_reg[5] <= s2_gray_reg;
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s2_move && s2_produce_reg)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s2_move && s2_produce_reg)
        begin
            mag_reg       <= mag;
            row_end_reg   <= s2_row_end_reg;
            frame_end_reg <= s2_frame_end_reg;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.magnitude = mag_reg;
    assign result.row_end   = row_end_reg;
    assign result.frame_end = frame_end_reg;

endmodule

>>> tb/rgsm_edge_checker.sv
`timescale 1ns / 1ps
// Checker for the gray-conversion Sobel edge block: tracks the frame
// registers, predicts each result from accepted pixels and compares them.
// Depends on rgsm_pkg and the channel interfaces in rgsm_ifs.sv.
module rgsm_edge_checker import rgsm_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    rgsm_pixel_if       pixel,
    rgsm_result_if      result,
    rgsm_cfg_if         cfg,
    output int unsigned fail_count,
    output int unsigned pending,
    output int unsigned next_col,
    output int unsigned next_row
);

    // BT.709-style luma weights in Q0.16
    localparam int unsigned LUMA_R = 13933;
    localparam int unsigned LUMA_G = 46871;
    localparam int unsigned LUMA_B = 4732;
    localparam int unsigned WIDTH_AT_RESET  = 640;
    localparam int unsigned HEIGHT_AT_RESET = 480;
    localparam int unsigned MAG_CEILING     = 255;

    typedef struct packed {
        pixel_t magnitude;
        logic   row_end;
        logic   frame_end;
    } edge_item_t;

    logic [FW_W-1:0] width_q;
    logic [FH_W-1:0] height_q;
    pixel_t          gray_one_above [MAX_WIDTH];
    pixel_t          gray_two_above [MAX_WIDTH];
    // [0..2] column two back (top, mid, bottom), [3..5] column one back
    pixel_t          window [6];
    int unsigned     col_q;
    int unsigned     row_q;
    int unsigned     fails;
    edge_item_t      expected_edges [$];

    always @(posedge clk or negedge rst_n)
    begin : track
        int unsigned gray, w_eff, h_eff, col, idx;
        int unsigned top_v, mid_v, bot_v;
        int unsigned right_s, left_s, lower_s, upper_s, mag;
        logic        last_col, last_row;
        edge_item_t  want;

        if (!rst_n)
        begin
            width_q  = WIDTH_AT_RESET;
            height_q = HEIGHT_AT_RESET;
            for (int i = 0; i < 6; i++)
                window[i] = '0;
            col_q = 0;
            row_q = 0;
            fails = 0;
            expected_edges.delete();
            fail_count <= 0;
            pending    <= 0;
            next_col   <= 0;
            next_row   <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_FRAME_WIDTH)
                    width_q = cfg.data[FW_W-1:0];
                else if (cfg.index == REG_FRAME_HEIGHT)
                    height_q = cfg.data[FH_W-1:0];
            end

            if (result.valid && result.ready)
            begin
                if (expected_edges.size() == 0)
                begin
                    fails++;
                    $display("%0t: result with nothing expected: magnitude %0d row_end %0b frame_end %0b",
                             $time, result.magnitude, result.row_end, result.frame_end);
                end
                else
                begin
                    want = expected_edges.pop_front();
                    if (result.magnitude !== want.magnitude)
                    begin
                        fails++;
                        $display("%0t: magnitude expected %0d, got %0d",
                                 $time, want.magnitude, result.magnitude);
                    end
                    if (result.row_end !== want.row_end)
                    begin
                        fails++;
                        $display("%0t: row_end expected %0b, got %0b",
                                 $time, want.row_end, result.row_end);
                    end
                    if (result.frame_end !== want.frame_end)
                    begin
                        fails++;
                        $display("%0t: frame_end expected %0b, got %0b",
                                 $time, want.frame_end, result.frame_end);
                    end
                end
            end

            if (pixel.valid && pixel.ready)
            begin
                gray = (LUMA_R * pixel.red + LUMA_G * pixel.green + LUMA_B * pixel.blue) >> 16;
                w_eff = width_q;
                if (w_eff < 3)
                    w_eff = 3;
                if (w_eff > MAX_WIDTH)
                    w_eff = MAX_WIDTH;
                h_eff = (height_q < 3) ? 3 : height_q;

                // a column left over from a wider setting ends the row at once
                col      = (col_q >= w_eff) ? w_eff - 1 : col_q;
                idx      = col % MAX_WIDTH;
                last_col = (col >= w_eff - 1);
                last_row = (row_q >= h_eff - 1);

                top_v = gray_two_above[idx];
                mid_v = gray_one_above[idx];
                bot_v = gray;

                if (row_q >= 2 && col >= 2)
                begin
                    right_s = top_v + 2 * mid_v + bot_v;
                    left_s  = window[0] + 2 * window[1] + window[2];
                    lower_s = window[2] + 2 * window[5] + bot_v;
                    upper_s = window[0] + 2 * window[3] + top_v;
                    mag = ((right_s > left_s) ? right_s - left_s : left_s - right_s)
                        + ((lower_s > upper_s) ? lower_s - upper_s : upper_s - lower_s);
                    if (mag > MAG_CEILING)
                        mag = MAG_CEILING;
                    want.magnitude = pixel_t'(mag);
                    want.row_end   = last_col;
                    want.frame_end = last_col && last_row;
                    expected_edges.push_back(want);
                end

                window[0] = window[3];
                window[1] = window[4];
                window[2] = window[5];
                window[3] = pixel_t'(top_v);
                window[4] = pixel_t'(mid_v);
                window[5] = pixel_t'(bot_v);
                gray_two_above[idx] = pixel_t'(mid_v);
                gray_one_above[idx] = pixel_t'(gray);

                if (last_col)
                begin
                    col_q = 0;
                    row_q = last_row ? 0 : ((row_q + 1) & 32'hFFF);
                end
                else
                    col_q = col + 1;
            end

            fail_count <= fails;
            pending    <= expected_edges.size();
            next_col   <= col_q;
            next_row   <= row_q;
        end
    end

endmodule

>>> tb/tb_rgb_gray_sobel_magnitude_top.sv
`timescale 1ns / 1ps
// Testbench top for the gray-conversion Sobel edge block: pixel stimulus,
// frame register writes, result back-pressure and the final verdict.
// Depends on rgsm_pkg, rgsm_ifs.sv, the block and rgsm_edge_checker.
module tb_rgb_gray_sobel_magnitude_top;
    import rgsm_pkg::*;

    typedef logic [FW_W-1:0] width_t;
    typedef logic [FH_W-1:0] height_t;

    localparam int unsigned CLK_HALF       = 4;
    localparam int unsigned RESET_CYCLES   = 5;
    localparam int unsigned IDLE_PCT       = 34;
    // leave some margin after the last result
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned RANDOM_ITEMS   = 310;
    localparam int unsigned BURST_MAX      = 80;
    localparam int unsigned CYCLE_LIMIT    = 200000;
    // flat-out frame, 140 interior results
    localparam int unsigned PRESS_W        = 16;
    localparam int unsigned PRESS_H        = 12;
    // receiver back-pressure plan, counted in accepted results
    localparam int unsigned HOLD_AT_RESULT = 100;
    localparam int unsigned HOLD_CYCLES    = 64;
    localparam int unsigned RX_STEADY_FROM = 20;
    localparam int unsigned RX_STEADY_TO   = 90;

    // directed pixels as {blue, green, red}
    localparam logic [23:0] WHITE      = 24'hFFFFFF;
    localparam logic [23:0] BLACK      = 24'h000000;
    localparam logic [23:0] RED_ONLY   = 24'h0000FF;
    localparam logic [23:0] GREEN_ONLY = 24'h00FF00;
    localparam logic [23:0] BLUE_ONLY  = 24'hFF0000;
    // 5 x 4 frame: a hard vertical edge that saturates, pure single channels
    // in the last column, and a bottom row that flips the edge over
    localparam logic [23:0] EDGE_PATTERN [20] = '{
        WHITE, WHITE, BLACK, BLACK, RED_ONLY,
        WHITE, WHITE, BLACK, BLACK, GREEN_ONLY,
        WHITE, WHITE, BLACK, BLACK, BLUE_ONLY,
        BLACK, BLACK, WHITE, WHITE, WHITE
    };

    logic        clk;
    logic        rst_n;
    logic        steady_send;
    width_t      cur_width;
    height_t     cur_height;
    int unsigned fail_count;
    int unsigned pending;
    int unsigned next_col;
    int unsigned next_row;
    int unsigned cycle_count;

    rgsm_pixel_if  pix_ch ();
    rgsm_result_if res_ch ();
    rgsm_cfg_if    cfg_ch ();

    rgb_gray_sobel_magnitude_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pix_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    rgsm_edge_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel      (pix_ch),
        .result     (res_ch),
        .cfg        (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending),
        .next_col   (next_col),
        .next_row   (next_row)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Offer one pixel, with random idle cycles in front unless a steady
    // stretch is on. Returns on the edge that accepted it; valid stays high
    // so the next call can follow back to back.
    task automatic send_pixel(input pixel_t b, input pixel_t g, input pixel_t r);
        while (!steady_send && $urandom_range(99) < IDLE_PCT)
        begin
            pix_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.blue  <= b;
        pix_ch.green <= g;
        pix_ch.red   <= r;
        @(posedge clk);
        while (!pix_ch.ready)
            @(posedge clk);
    endtask

    // Random content, with solid black and white often enough to hit both
    // a flat window and a saturated edge.
    task automatic send_random_run(input int unsigned count);
        pixel_t b, g, r;
        for (int unsigned n = 0; n < count; n++)
        begin
            case ($urandom_range(9))
                0:
                begin
                    b = '0;
                    g = '0;
                    r = '0;
                end
                1:
                begin
                    b = '1;
                    g = '1;
                    r = '1;
                end
                default:
                begin
                    b = pixel_t'($urandom);
                    g = pixel_t'($urandom);
                    r = pixel_t'($urandom);
                end
            endcase
            send_pixel(b, g, r);
        end
    endtask

    // Stop offering pixels and wait until every predicted result is back.
    // The first edge lets the checker count a pixel taken on the last edge;
    // the settle time covers pixels in flight that give no result.
    task automatic wait_drained();
        pix_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Both frame registers in one burst; valid stays high between them.
    // Bit 11 of a width write lies outside the register and is randomised.
    task automatic write_frame_size(input width_t w, input height_t h);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= REG_FRAME_WIDTH;
        cfg_ch.data  <= cfg_data_t'({1'($urandom_range(1)), w});
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.index <= REG_FRAME_HEIGHT;
        cfg_ch.data  <= cfg_data_t'(h);
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        cur_width  = w;
        cur_height = h;
    endtask

    // Result side: random stalls, a stretch with no stalls at all and one
    // long hold-off in the flat-out frame, so the pipeline fills and
    // pixel.ready drops.
    initial
    begin : result_sink
        int unsigned taken;
        int unsigned hold_left;

        taken     = 0;
        hold_left = 0;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_left != 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (taken >= RX_STEADY_FROM && taken < RX_STEADY_TO)
                res_ch.ready <= 1'b1;
            else
                res_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
            begin
                taken++;
                if (taken == HOLD_AT_RESULT)
                    hold_left = HOLD_CYCLES;
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned random_sent;
        int unsigned w_eff;
        int unsigned h_eff;
        int unsigned new_w_eff;
        int unsigned left;
        int unsigned burst;
        width_t      new_w;
        height_t     new_h;

        rst_n        <= 1'b0;
        steady_send  <= 1'b0;
        pix_ch.valid <= 1'b0;
        pix_ch.blue  <= '0;
        pix_ch.green <= '0;
        pix_ch.red   <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_FRAME_WIDTH;
        cfg_ch.data  <= '0;
        cur_width     = FW_RESET;
        cur_height    = FH_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frame: border pixels give nothing, six interior results
        // carry the row and frame marks.
        write_frame_size(width_t'(5), height_t'(4));
        for (int i = 0; i < 20; i++)
            send_pixel(EDGE_PATTERN[i][23:16], EDGE_PATTERN[i][15:8], EDGE_PATTERN[i][7:0]);
        wait_drained();

        // One whole frame with the sender flat out; the receiver runs
        // steady for part of it, then holds off while pixels keep coming.
        write_frame_size(width_t'(PRESS_W), height_t'(PRESS_H));
        steady_send <= 1'b1;
        send_random_run(PRESS_W * PRESS_H);
        steady_send <= 1'b0;
        wait_drained();

        // Tallest frame, then cut short mid-frame by a height below three:
        // the row already past the new last row ends the frame at its end.
        write_frame_size(width_t'(3), height_t'(4095));
        send_random_run(30);
        wait_drained();
        write_frame_size(width_t'(3), height_t'(2));

        // Random phases: mostly whole frames with random content, the rest
        // frames cut short by new sizes, including out-of-range widths and
        // heights and rows already past a narrower width.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            wait_drained();
            w_eff = cur_width;
            if (w_eff < 3)
                w_eff = 3;
            if (w_eff > MAX_WIDTH)
                w_eff = MAX_WIDTH;
            h_eff = (cur_height < 3) ? 3 : cur_height;

            // wide rows are kept short-lived
            if (w_eff > 16 || $urandom_range(99) < 60)
            begin
                case ($urandom_range(9))
                    0:       new_w = width_t'($urandom_range(2));
                    1:       new_w = width_t'($urandom_range(2047, MAX_WIDTH + 1));
                    2:       new_w = width_t'(MAX_WIDTH);
                    default: new_w = width_t'($urandom_range(9, 3));
                endcase
                case ($urandom_range(9))
                    0:       new_h = height_t'($urandom_range(2));
                    1:       new_h = height_t'($urandom_range(4095, 8));
                    default: new_h = height_t'($urandom_range(7, 3));
                endcase
                // widening part way through a frame would read line store
                // entries this frame has not written yet
                new_w_eff = new_w;
                if (new_w_eff < 3)
                    new_w_eff = 3;
                if (new_w_eff > MAX_WIDTH)
                    new_w_eff = MAX_WIDTH;
                if ((next_col != 0 || next_row != 0) && new_w_eff > w_eff)
                    new_w = cur_width;
                write_frame_size(new_w, new_h);
                w_eff = new_w;
                if (w_eff < 3)
                    w_eff = 3;
                if (w_eff > MAX_WIDTH)
                    w_eff = MAX_WIDTH;
                h_eff = (new_h < 3) ? 3 : new_h;
            end

            // pixels up to the end of the current frame
            left = (next_col >= w_eff) ? 1 : w_eff - next_col;
            if (next_row < h_eff - 1)
                left += (h_eff - 1 - next_row) * w_eff;

            if (left > BURST_MAX || $urandom_range(99) < 25)
                burst = $urandom_range((left > BURST_MAX) ? BURST_MAX : left, 1);
            else
                burst = left;
            send_random_run(burst);
            random_sent += burst;
        end

        wait_drained();
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/rgsm_pkg.sv
hw/rtl/rgsm_ifs.sv
hw/rtl/rgb_gray_sobel_magnitude_top.sv
tb/rgsm_edge_checker.sv
tb/tb_rgb_gray_sobel_magnitude_top.sv
